// ----- design/wsrgb_pkg.sv -----
// Shared widths, register indexes and the color mapping of the wheel speed block.
`timescale 1ns / 1ps
package wsrgb_pkg;

  localparam int DEB_W  = 8;
  localparam int TMO_W  = 16;
  localparam int NUM_W  = 24;
  localparam int UNCH_W = 16;
  localparam int ROT_W  = 17;
  localparam int COL_W  = 8;
  localparam int LVL_W  = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = NUM_W;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUMER    = 2'd2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd2;
  localparam logic [TMO_W-1:0] TIMEOUT_RST  = 16'd1000;
  localparam logic [NUM_W-1:0] NUMER_RST    = 24'd40355;

  localparam logic [LVL_W-1:0] BAND1 = 10'd255;
  localparam logic [LVL_W-1:0] BAND2 = 10'd510;
  localparam logic [LVL_W-1:0] BAND3 = 10'd765;

  localparam logic       CAUSE_EDGE    = 1'b0;
  localparam logic       CAUSE_TIMEOUT = 1'b1;

  // Result request from the tick logic to the divider control.
  typedef struct packed {
    logic             fire;
    logic             cause;
    logic             zero;
    logic [ROT_W-1:0] period;
  } wsrgb_evt_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } wsrgb_rgb_t;

  function automatic wsrgb_rgb_t wsrgb_map(input logic [NUM_W-1:0] level, input logic zero);
    wsrgb_rgb_t       c;
    logic [LVL_W-1:0] l;
    logic [LVL_W-1:0] t0;
    logic [LVL_W-1:0] t1;
    c  = '0;
    l  = level[LVL_W-1:0];
    t0 = '0;
    t1 = '0;
    if (zero || level == '0 || level[NUM_W-1:LVL_W] != '0 || l >= BAND3) begin
      c = '0;
    end else if (l < BAND1) begin
      c.green = l[COL_W-1:0];
    end else if (l < BAND2) begin
      t0 = BAND2 - l;
      t1 = l - BAND1;
      c.green = t0[COL_W-1:0];
      c.blue  = t1[COL_W-1:0];
    end else begin
      t0 = l - BAND2;
      t1 = BAND3 - l;
      c.red  = t0[COL_W-1:0];
      c.blue = t1[COL_W-1:0];
    end
    return c;
  endfunction

endpackage

// ----- design/wsrgb_tick.sv -----
// Per-tick debounce, rotation counter and result decision.
`timescale 1ns / 1ps
module wsrgb_tick import wsrgb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  logic             raw,
  input  logic [DEB_W-1:0] debounce_ms,
  input  logic [TMO_W-1:0] timeout_ms,
  output wsrgb_evt_t       evt
);

  logic              prev_r, prev_nxt;
  logic              stable_r, stable_nxt;
  logic [UNCH_W-1:0] unch_r, unch_nxt;
  logic [ROT_W-1:0]  rot_r, rot_nxt;
  logic [ROT_W-1:0]  rot_inc;
  logic              accept_lvl;
  logic              edge_fire;
  logic              tmo_fire;

  always_comb begin
    rot_inc = (rot_r == '1) ? rot_r : rot_r + ROT_W'(1);
    if (raw != prev_r) begin
      unch_nxt = '0;
    end else begin
      unch_nxt = (unch_r == '1) ? unch_r : unch_r + UNCH_W'(1);
    end
    accept_lvl = (unch_nxt > UNCH_W'(debounce_ms)) && (raw != stable_r);
    edge_fire  = accept_lvl && !raw;
    tmo_fire   = !edge_fire && (rot_inc > ROT_W'(timeout_ms));
    stable_nxt = accept_lvl ? raw : stable_r;
    prev_nxt   = raw;
    rot_nxt    = (edge_fire || tmo_fire) ? '0 : rot_inc;

    evt.fire   = tick && (edge_fire || tmo_fire);
    evt.cause  = edge_fire ? CAUSE_EDGE : CAUSE_TIMEOUT;
    evt.period = rot_inc;
    evt.zero   = (rot_inc == '0) || (rot_inc >= ROT_W'(timeout_ms));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 1'b0;
      stable_r <= 1'b0;
      unch_r   <= '0;
      rot_r    <= '0;
    end else if (tick) begin
      prev_r   <= prev_nxt;
      stable_r <= stable_nxt;
      unch_r   <= unch_nxt;
      rot_r    <= rot_nxt;
    end
  end

endmodule

// ----- design/wsrgb_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module wsrgb_div import wsrgb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [ROT_W-1:0] denom,
  output logic             last,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ROT_W:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]  shf_r, shf_nxt;
  logic [ROT_W-1:0]  dvs_r, dvs_nxt;
  logic [ROT_W:0]    rem_sh;
  logic              ge;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    dvs_nxt  = dvs_r;
    // Numerator bits leave at the top of shf_r while quotient bits enter at the bottom.
    rem_sh   = {rem_r[ROT_W-1:0], shf_r[NUM_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    last     = busy_r && (cnt_r == CNT_LAST);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      shf_nxt  = numer;
      dvs_nxt  = denom;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      shf_nxt = {shf_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign quot = shf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

// ----- design/wheel_speed_to_rgb_color_top.sv -----
// Top level: configuration registers, sequencing of the divider and the output register.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------
//  input   | in_sensor_level                         | in_valid/in_ready
//  output  | out_red out_green out_blue out_cause    | out_valid/out_ready
//  config  | cfg_index cfg_wdata                     | cfg_we, no wait
//
// A tick that causes no result leaves the input ready for the next tick. A tick that
// causes a result stalls the input through acceptance, the bit-serial divider (one
// quotient bit per cycle) and the load state, which maps the level and loads the
// output register. While the output register still holds an untaken transaction, the
// finished result waits and the input stays stalled. Reset is synchronous.
`timescale 1ns / 1ps
module wheel_speed_to_rgb_color_top import wsrgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_sensor_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COL_W-1:0]      out_red,
  output logic [COL_W-1:0]      out_green,
  output logic [COL_W-1:0]      out_blue,
  output logic                  out_cause,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [DEB_W-1:0] deb_r;
  logic [TMO_W-1:0] tmo_r;
  logic [NUM_W-1:0] numer_r;
  logic             cause_r;
  logic             zero_r;
  logic             out_valid_r;
  logic             out_free;
  wsrgb_rgb_t       col_r;
  wsrgb_rgb_t       col;
  wsrgb_evt_t       evt;
  logic             tick;
  logic             div_last;
  logic [NUM_W-1:0] quot;

  assign in_ready = (state_r == ST_IDLE);
  assign tick     = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  wsrgb_tick u_tick (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .raw         (in_sensor_level),
    .debounce_ms (deb_r),
    .timeout_ms  (tmo_r),
    .evt         (evt)
  );

  wsrgb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (evt.fire),
    .numer (numer_r),
    .denom (evt.period),
    .last  (div_last),
    .quot  (quot)
  );

  assign col = wsrgb_map(quot, zero_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (evt.fire) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      deb_r       <= DEBOUNCE_RST;
      tmo_r       <= TIMEOUT_RST;
      numer_r     <= NUMER_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOAD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: deb_r   <= cfg_wdata[DEB_W-1:0];
          REG_TIMEOUT:  tmo_r   <= cfg_wdata[TMO_W-1:0];
          REG_NUMER:    numer_r <= cfg_wdata[NUM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload: capture the request flags at the tick, the colors at load.
  always_ff @(posedge clk) begin
    if (evt.fire) begin
      cause_r <= evt.cause;
      zero_r  <= evt.zero;
    end
    if (state_r == ST_LOAD && out_free) begin
      col_r     <= col;
      out_cause <= cause_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = col_r.red;
  assign out_green = col_r.green;
  assign out_blue  = col_r.blue;

endmodule
